@@ sv/sgps_pkg.sv @@
// Shared types, constants and the gamma curve table for the sharpen-gamma pixel stream.
package sgps_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_CH    = 3;
    localparam int COORD_W   = 11;
    localparam int CFG_W     = 12;
    localparam int ROM_DEPTH = 256;

    typedef logic [PIX_W-1:0]          t_chan;
    typedef t_chan [NUM_CH-1:0]        t_pixel;
    typedef logic [COORD_W-1:0]        t_coord;
    typedef logic [CFG_W-1:0]          t_cfg_data;
    typedef logic [ROM_DEPTH-1:0][PIX_W-1:0] t_gamma_rom;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Which of the up to four finished pixels a beat releases
    typedef enum logic [1:0] {
        RES_UP_LEFT,
        RES_UP_HERE,
        RES_ROW_LEFT,
        RES_ROW_HERE
    } t_res_slot;

    // Position of a beat relative to the image edges
    typedef struct packed {
        logic col_ge1;
        logic col_ge2;
        logic col_last;
        logic row_ge1;
        logic row_ge2;
        logic row_last;
    } t_pos_flags;

    // Side data of one result beat
    typedef struct packed {
        t_coord col;
        t_coord row;
        logic   last_of_run;
        logic   frame_done;
    } t_res_meta;

    // Entry i is the largest v with 255*v^5 <= i^6; the curve rises by at most
    // two per entry, so a few trial steps per entry are enough.
    function automatic t_gamma_rom build_gamma_rom();
        t_gamma_rom      rom;
        longint unsigned ii;
        longint unsigned i6;
        longint unsigned n;
        longint unsigned n5;
        longint unsigned v;
        v = 0;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            ii = 64'(i);
            i6 = ii * ii * ii * ii * ii * ii;
            for (int k = 0; k < 4; k++) begin
                if (v < 64'd255) begin
                    n  = v + 64'd1;
                    n5 = n * n * n * n * n * 64'd255;
                    if (n5 <= i6) begin
                        v = n;
                    end
                end
            end
            rom[i] = v[PIX_W-1:0];
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma_rom();

endpackage

@@ sv/sgps_pixel_if.sv @@
// Input channel: one RGB pixel per beat.
interface sgps_pixel_if import sgps_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

@@ sv/sgps_result_if.sv @@
// Output channel: one finished pixel with its position per beat.
interface sgps_result_if import sgps_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord out_col;
    t_coord out_row;
    t_chan  red_out;
    t_chan  green_out;
    t_chan  blue_out;
    logic   last_of_run;
    logic   frame_done;

    modport source (output valid, output out_col, output out_row, output red_out,
                    output green_out, output blue_out, output last_of_run,
                    output frame_done, input ready);
    modport sink   (input valid, input out_col, input out_row, input red_out,
                    input green_out, input blue_out, input last_of_run,
                    input frame_done, output ready);
endinterface

@@ sv/sgps_lane.sv @@
// One channel lane: cross-stencil sharpen followed by the gamma table.
module sgps_lane import sgps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_adv,
    input  t_chan i_centre,
    input  t_chan i_left,
    input  t_chan i_right,
    input  t_chan i_up,
    input  t_chan i_down,
    output t_chan o_value
);

    logic [PIX_W+1:0] sum;
    logic [PIX_W-1:0] quarter;
    logic [PIX_W:0]   twice;
    logic [PIX_W:0]   diff;
    logic             below;

    logic [PIX_W-1:0] r_idx;
    logic             r_sat;
    t_chan            r_value;

    // Twice the centre less a quarter of the neighbour sum
    always_comb begin
        sum     = {2'b00, i_left} + {2'b00, i_right} + {2'b00, i_up} + {2'b00, i_down};
        quarter = sum[PIX_W+1:2];
        twice   = {i_centre, 1'b0};
        below   = twice < {1'b0, quarter};
        diff    = twice - {1'b0, quarter};
    end

    // Hold the table index and the saturation flag
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx <= diff[PIX_W-1:0];
            r_sat <= below | diff[PIX_W];
        end
    end

    // Look up the curve; a wrapped negative or an overflow gives full scale
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= r_sat ? {PIX_W{1'b1}} : GAMMA_ROM[r_idx];
        end
    end

    assign o_value = r_value;

endmodule

@@ sv/sgps_line_store.sv @@
// Two row stores with read-modify-write per column and the first pipeline stage.
module sgps_line_store import sgps_pkg::*; #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int RW    = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [AW-1:0] i_addr,
    input  logic [RW-1:0] i_row,
    input  t_pos_flags    i_flags,
    input  t_pixel        i_pixel,
    input  logic          i_take,
    output logic          o_valid,
    output t_pixel        o_pixel,
    output t_pixel        o_prev,
    output t_pixel        o_older,
    output logic [AW-1:0] o_col,
    output logic [RW-1:0] o_row,
    output t_pos_flags    o_flags
);

    t_pixel mem_prev  [DEPTH];
    t_pixel mem_older [DEPTH];

    logic          r_valid;
    logic          n_valid;
    logic [AW-1:0] r_addr;
    logic [RW-1:0] r_row;
    t_pos_flags    r_flags;
    t_pixel        r_pixel;
    t_pixel        r_prev_rd;
    t_pixel        r_older_rd;

    // Push the column down one row as the beat leaves this stage
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            mem_prev[r_addr]  <= r_pixel;
            mem_older[r_addr] <= r_prev_rd;
        end
    end

    // Read the column of the new beat; forward a write to the same column
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (i_take && (i_addr == r_addr)) begin
                r_prev_rd  <= r_pixel;
                r_older_rd <= r_prev_rd;
            end else begin
                r_prev_rd  <= mem_prev[i_addr];
                r_older_rd <= mem_older[i_addr];
            end
        end
    end

    // Hold the beat payload
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_addr  <= i_addr;
            r_row   <= i_row;
            r_flags <= i_flags;
            r_pixel <= i_pixel;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_fire) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_prev  = r_prev_rd;
    assign o_older = r_older_rd;
    assign o_col   = r_addr;
    assign o_row   = r_row;
    assign o_flags = r_flags;

endmodule

@@ sv/sgps_window.sv @@
// Stencil window over three rows and the sequencer that releases finished pixels.
module sgps_window import sgps_pkg::*; #(
    parameter int CW = 11,
    parameter int RW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_beat_valid,
    input  t_pixel        i_pixel,
    input  t_pixel        i_prev,
    input  t_pixel        i_older,
    input  logic [CW-1:0] i_col,
    input  logic [RW-1:0] i_row,
    input  t_pos_flags    i_flags,
    input  logic          i_adv,
    output logic          o_take,
    output logic          o_valid,
    output t_pixel        o_centre,
    output t_pixel        o_left,
    output t_pixel        o_right,
    output t_pixel        o_up,
    output t_pixel        o_down,
    output t_res_meta     o_meta
);

    localparam int XW = (CW > COORD_W) ? CW : COORD_W;
    localparam int YW = (RW > COORD_W) ? RW : COORD_W;

    // Index 0 is the newest column, 1 and 2 the ones before it (r_ow holds only 0 and 1)
    t_pixel        r_cw [3];
    t_pixel        r_pw [3];
    t_pixel        r_ow [2];
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pos_flags    r_flags;
    logic [3:0]    r_mask;
    logic [3:0]    n_mask;

    logic          free;
    logic          take;
    logic          issue;
    t_res_slot     slot;
    logic [3:0]    slot_bit;
    logic [3:0]    beat_mask;
    t_pixel        s_ctr;
    t_pixel        s_lft;
    t_pixel        s_rgt;
    t_pixel        s_up;
    t_pixel        s_dn;
    logic [CW-1:0] s_x;
    logic [RW-1:0] s_y;
    logic [XW-1:0] x_wide;
    logic [YW-1:0] y_wide;

    logic          r_valid;
    t_pixel        r_ctr;
    t_pixel        r_lft;
    t_pixel        r_rgt;
    t_pixel        r_up;
    t_pixel        r_dn;
    t_res_meta     r_meta;

    // Take a new beat once the pending pixels are out or the last one goes now
    assign free  = (r_mask == 4'd0) || (i_adv && ((r_mask & (r_mask - 4'd1)) == 4'd0));
    assign take  = i_beat_valid && free;
    assign issue = i_adv && (r_mask != 4'd0);

    // Finished pixels of a beat, in row then column order
    assign beat_mask = {i_flags.col_last & i_flags.row_last,
                        i_flags.col_ge1  & i_flags.row_last,
                        i_flags.col_last & i_flags.row_ge1,
                        i_flags.col_ge1  & i_flags.row_ge1};

    // Pick the lowest pending pixel
    always_comb begin
        if (r_mask[0]) begin
            slot = RES_UP_LEFT;
        end else if (r_mask[1]) begin
            slot = RES_UP_HERE;
        end else if (r_mask[2]) begin
            slot = RES_ROW_LEFT;
        end else begin
            slot = RES_ROW_HERE;
        end
        slot_bit = 4'b0001 << slot;
    end

    // Gather the centre and its clamped neighbours
    always_comb begin
        case (slot)
            RES_UP_LEFT: begin
                s_ctr = r_pw[1];
                s_lft = r_flags.col_ge2 ? r_pw[2] : r_pw[1];
                s_rgt = r_pw[0];
                s_up  = r_flags.row_ge2 ? r_ow[1] : r_pw[1];
                s_dn  = r_cw[1];
                s_x   = r_col - CW'(1);
                s_y   = r_row - RW'(1);
            end
            RES_UP_HERE: begin
                s_ctr = r_pw[0];
                s_lft = r_flags.col_ge1 ? r_pw[1] : r_pw[0];
                s_rgt = r_pw[0];
                s_up  = r_flags.row_ge2 ? r_ow[0] : r_pw[0];
                s_dn  = r_cw[0];
                s_x   = r_col;
                s_y   = r_row - RW'(1);
            end
            RES_ROW_LEFT: begin
                s_ctr = r_cw[1];
                s_lft = r_flags.col_ge2 ? r_cw[2] : r_cw[1];
                s_rgt = r_cw[0];
                s_up  = r_flags.row_ge1 ? r_pw[1] : r_cw[1];
                s_dn  = r_cw[1];
                s_x   = r_col - CW'(1);
                s_y   = r_row;
            end
            default: begin
                s_ctr = r_cw[0];
                s_lft = r_flags.col_ge1 ? r_cw[1] : r_cw[0];
                s_rgt = r_cw[0];
                s_up  = r_flags.row_ge1 ? r_pw[0] : r_cw[0];
                s_dn  = r_cw[0];
                s_x   = r_col;
                s_y   = r_row;
            end
        endcase
        x_wide = XW'(s_x);
        y_wide = YW'(s_y);
    end

    // Shift the window by one column on each new beat
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cw[0] <= i_pixel;
            r_cw[1] <= r_cw[0];
            r_cw[2] <= r_cw[1];
            r_pw[0] <= i_prev;
            r_pw[1] <= r_pw[0];
            r_pw[2] <= r_pw[1];
            r_ow[0] <= i_older;
            r_ow[1] <= r_ow[0];
            r_col   <= i_col;
            r_row   <= i_row;
            r_flags <= i_flags;
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (take) begin
            n_mask = beat_mask;
        end else if (issue) begin
            n_mask = r_mask & ~slot_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (i_adv) begin
                r_valid <= issue;
            end
        end
    end

    // Hold the gathered stencil for the lanes
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ctr              <= s_ctr;
            r_lft              <= s_lft;
            r_rgt              <= s_rgt;
            r_up               <= s_up;
            r_dn               <= s_dn;
            r_meta.col         <= x_wide[COORD_W-1:0];
            r_meta.row         <= y_wide[COORD_W-1:0];
            r_meta.last_of_run <= (r_mask & ~slot_bit) == 4'd0;
            r_meta.frame_done  <= slot == RES_ROW_HERE;
        end
    end

    assign o_take   = take;
    assign o_valid  = r_valid;
    assign o_centre = r_ctr;
    assign o_left   = r_lft;
    assign o_right  = r_rgt;
    assign o_up     = r_up;
    assign o_down   = r_dn;
    assign o_meta   = r_meta;

endmodule

@@ sv/sharpen_gamma_pixel_stream.sv @@
// Top level of the sharpen-gamma pixel stream: counters, configuration, lanes and output.
//
// Pixels enter on i_pix in raster order, one beat per clock when the block is
// ready. Each pixel is sharpened per channel with a cross stencil, clamped at the
// image edges, and passed through a gamma-1.2 table. Finished pixels leave on
// o_res with their column and row once their right and lower neighbours are in.
// The user must set width and height through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
// the block itself does not enforce this. A write restarts the frame at column 0, row 0.
// Throughput: one pixel per cycle while each pixel releases at most one result and
// the receiver does not stall. A pixel releases the one up and to its left, plus the
// one above it in the last column, the one to its left in the last row and itself
// in the last column of the last row, up to four in all; the single result port of
// the release sequencer issues them one at a time, so such a beat holds the input
// until its last result issues. A result reaches o_res through the row store read,
// window shift, stencil gather, sharpen and table lookup registers.
// Reset clears the position counters and all pipeline valids and sets each size to
// 2048, clamped to the maximum; the row stores are not cleared and need no clearing pass.
// When the receiver stalls, the output beat holds and the pipeline behind it
// stops; input is still taken until the row store stage is full.
module sharpen_gamma_pixel_stream import sgps_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int CHANNELS   = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sgps_pixel_if.sink    i_pix,
    sgps_result_if.source o_res,
    input  logic          i_cfg_we,
    input  t_cfg_idx      i_cfg_idx,
    input  t_cfg_data     i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LANES = (CHANNELS < NUM_CH) ? CHANNELS : NUM_CH;

    // Last index of a size register, with the size clamped to 1..max_v
    function automatic int last_index(input t_cfg_data v, input int max_v);
        int r;
        if (v == '0) begin
            r = 0;
        end else if (int'(v) > max_v) begin
            r = max_v - 1;
        end else begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          cfg_hit;

    logic          in_ready;
    logic          in_fire;
    t_pixel        in_pixel;
    t_pos_flags    in_flags;

    logic          ls_valid;
    t_pixel        ls_pixel;
    t_pixel        ls_prev;
    t_pixel        ls_older;
    logic [CW-1:0] ls_col;
    logic [RW-1:0] ls_row;
    t_pos_flags    ls_flags;
    logic          take;

    logic          adv;
    logic          win_valid;
    t_pixel        win_ctr;
    t_pixel        win_lft;
    t_pixel        win_rgt;
    t_pixel        win_up;
    t_pixel        win_dn;
    t_res_meta     win_meta;

    logic          r_a_valid;
    t_res_meta     r_a_meta;
    logic          r_out_valid;
    t_res_meta     r_out_meta;
    t_chan         lane_out [NUM_CH];

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(last_index(t_cfg_data'(2048), MAX_WIDTH));
            r_last_row <= RW'(last_index(t_cfg_data'(2048), MAX_HEIGHT));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_last_col <= CW'(last_index(i_cfg_data, MAX_WIDTH));
                CFG_IMAGE_HEIGHT: r_last_row <= RW'(last_index(i_cfg_data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_idx == CFG_IMAGE_WIDTH || i_cfg_idx == CFG_IMAGE_HEIGHT);

    // Position of the next input pixel
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_fire) begin
            if (r_col == r_last_col) begin
                n_col = '0;
                n_row = (r_row == r_last_row) ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Input handshake and edge flags of the arriving pixel
    assign in_ready    = !ls_valid || take;
    assign i_pix.ready = in_ready;
    assign in_fire     = i_pix.valid && in_ready;
    assign in_pixel    = {i_pix.blue_in, i_pix.green_in, i_pix.red_in};

    always_comb begin
        in_flags.col_ge1  = r_col != '0;
        in_flags.col_ge2  = r_col > CW'(1);
        in_flags.col_last = r_col == r_last_col;
        in_flags.row_ge1  = r_row != '0;
        in_flags.row_ge2  = r_row > RW'(1);
        in_flags.row_last = r_row == r_last_row;
    end

    sgps_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .RW    (RW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_addr  (r_col),
        .i_row   (r_row),
        .i_flags (in_flags),
        .i_pixel (in_pixel),
        .i_take  (take),
        .o_valid (ls_valid),
        .o_pixel (ls_pixel),
        .o_prev  (ls_prev),
        .o_older (ls_older),
        .o_col   (ls_col),
        .o_row   (ls_row),
        .o_flags (ls_flags)
    );

    // The back pipeline moves whenever the output beat is free or taken
    assign adv = !r_out_valid || o_res.ready;

    sgps_window #(
        .CW (CW),
        .RW (RW)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (ls_valid),
        .i_pixel      (ls_pixel),
        .i_prev       (ls_prev),
        .i_older      (ls_older),
        .i_col        (ls_col),
        .i_row        (ls_row),
        .i_flags      (ls_flags),
        .i_adv        (adv),
        .o_take       (take),
        .o_valid      (win_valid),
        .o_centre     (win_ctr),
        .o_left       (win_lft),
        .o_right      (win_rgt),
        .o_up         (win_up),
        .o_down       (win_dn),
        .o_meta       (win_meta)
    );

    // One lane per active channel; absent channels read as zero
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        if (c < LANES) begin : g_on
            sgps_lane u_lane (
                .i_clk    (i_clk),
                .i_adv    (adv),
                .i_centre (win_ctr[c]),
                .i_left   (win_lft[c]),
                .i_right  (win_rgt[c]),
                .i_up     (win_up[c]),
                .i_down   (win_dn[c]),
                .o_value  (lane_out[c])
            );
        end else begin : g_off
            assign lane_out[c] = '0;
        end
    end

    // Carry the side data alongside the lanes and merge at the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= win_valid;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_meta   <= win_meta;
            r_out_meta <= r_a_meta;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_col     = r_out_meta.col;
    assign o_res.out_row     = r_out_meta.row;
    assign o_res.red_out     = lane_out[0];
    assign o_res.green_out   = lane_out[1];
    assign o_res.blue_out    = lane_out[2];
    assign o_res.last_of_run = r_out_meta.last_of_run;
    assign o_res.frame_done  = r_out_meta.frame_done;

endmodule

@@ test/sharpen_gamma_pixel_stream_tb.sv @@
// Self-checking testbench for the sharpen-gamma pixel stream: own predictor, random idling.
module sharpen_gamma_pixel_stream_tb;
    import sgps_pkg::*;

    localparam int          MAX_W        = 2048;
    localparam int          MAX_H        = 2048;
    localparam int          HALF_PERIOD  = 5;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_ITEMS = 80;
    localparam int          EDGE_ITEMS   = 24;
    localparam int unsigned CYCLE_LIMIT  = 100000;

    // One finished pixel as it leaves the block
    typedef struct packed {
        t_coord col;
        t_coord row;
        t_chan  red;
        t_chan  green;
        t_chan  blue;
        logic   last_of_run;
        logic   frame_done;
    } t_finished_pixel;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    sgps_pixel_if  pix_if ();
    sgps_result_if res_if ();

    sharpen_gamma_pixel_stream #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .CHANNELS   (3)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor state: size registers, raster position, row stores and recent pixels
    t_cfg_data       width_reg  = 12'd2048;
    t_cfg_data       height_reg = 12'd2048;
    int unsigned     col_cnt    = 0;
    int unsigned     row_cnt    = 0;
    t_pixel          older_row [MAX_W];
    t_pixel          prev_row  [MAX_W];
    t_pixel          recent_px [3];
    t_chan           gamma_curve [256];
    t_finished_pixel pixels_due [$];

    int unsigned bad_beats   = 0;
    int unsigned cycle_count = 0;
    bit          sender_gaps_on     = 1'b1;
    bit          receiver_stalls_on = 1'b1;

    always #(HALF_PERIOD) clk = ~clk;

    // Build the gamma-1.2 curve: largest v with 255*v^5 <= i^6, searched downwards
    initial begin : gamma_fill
        longint unsigned li;
        longint unsigned lv;
        longint unsigned i6;
        int              v;
        for (int i = 0; i < 256; i++) begin
            li = i;
            i6 = li * li * li * li * li * li;
            for (v = 255; v > 0; v--) begin
                lv = v;
                if (lv * lv * lv * lv * lv * 255 <= i6) break;
            end
            gamma_curve[i] = 8'(v);
        end
    end

    function automatic t_pixel rgb(t_chan r, t_chan g, t_chan b);
        return {b, g, r};
    endfunction

    function automatic int unsigned eff_size(t_cfg_data r, int unsigned maxv);
        int unsigned rv;
        rv = r;
        if (rv < 1) return 1;
        if (rv > maxv) return maxv;
        return rv;
    endfunction

    // rel counts rows back from the current one: 0 current, 1 previous, 2 older
    function automatic t_chan stencil_read(int unsigned col, int unsigned rel, int ch);
        int unsigned k;
        k = col_cnt - col;
        if (rel == 0) return (k < 3) ? recent_px[k][ch] : 8'd0;
        if (col >= MAX_W) return 8'd0;
        return (rel == 1) ? prev_row[col][ch] : older_row[col][ch];
    endfunction

    // Sharpen one pixel with edge clamping, then pass it through the curve
    function automatic t_finished_pixel sharpen_at(int unsigned x, int unsigned y,
                                                   int unsigned w, int unsigned h);
        t_finished_pixel fp;
        t_chan           vals [3];
        int unsigned     xl, xr, yu, yd, ctr, sum, s;
        xl = (x > 0) ? x - 1 : x;
        xr = (x + 1 < w) ? x + 1 : x;
        yu = (y > 0) ? y - 1 : y;
        yd = (y + 1 < h) ? y + 1 : y;
        for (int ch = 0; ch < 3; ch++) begin
            ctr = stencil_read(x, row_cnt - y, ch);
            sum = 0;
            sum += stencil_read(xl, row_cnt - y, ch);
            sum += stencil_read(xr, row_cnt - y, ch);
            sum += stencil_read(x, row_cnt - yu, ch);
            sum += stencil_read(x, row_cnt - yd, ch);
            s = (2 * ctr - (sum >> 2)) & 32'hFFFF;
            vals[ch] = (s > 255) ? 8'd255 : gamma_curve[s];
        end
        fp.col         = t_coord'(x);
        fp.row         = t_coord'(y);
        fp.red         = vals[0];
        fp.green       = vals[1];
        fp.blue        = vals[2];
        fp.last_of_run = 1'b0;
        fp.frame_done  = (x == w - 1 && y == h - 1);
        return fp;
    endfunction

    // Move one column of the current row into the row stores
    task automatic roll_column(int unsigned col);
        int unsigned k;
        k = col_cnt - col;
        if (col >= MAX_W || k >= 3) return;
        older_row[col] = prev_row[col];
        prev_row[col]  = recent_px[k];
    endtask

    // Advance the predictor by one accepted pixel and queue the pixels it finishes
    task automatic predict_pixel(t_pixel px);
        t_finished_pixel batch [4];
        int unsigned     w, h, cx, cy, x, y;
        int              n;
        bit              ok;
        w  = eff_size(width_reg, MAX_W);
        h  = eff_size(height_reg, MAX_H);
        cx = col_cnt;
        cy = row_cnt;
        n  = 0;
        if (cx >= w || cy >= h) begin
            cx = 0;
            cy = 0;
            col_cnt = 0;
            row_cnt = 0;
        end
        recent_px[2] = recent_px[1];
        recent_px[1] = recent_px[0];
        recent_px[0] = px;
        for (int yi = 0; yi < 2; yi++) begin
            for (int xi = 0; xi < 2; xi++) begin
                if (yi == 0) begin
                    ok = (cy >= 1);
                    y  = cy - 1;
                end else begin
                    ok = (cy == h - 1);
                    y  = cy;
                end
                if (xi == 0) begin
                    ok = ok && (cx >= 1);
                    x  = cx - 1;
                end else begin
                    ok = ok && (cx == w - 1);
                    x  = cx;
                end
                if (ok) begin
                    batch[n] = sharpen_at(x, y, w, h);
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            batch[i].last_of_run = (i == n - 1);
            pixels_due.push_back(batch[i]);
        end
        if (cx >= 2) roll_column(cx - 2);
        if (cx == w - 1) begin
            if (cx >= 1) roll_column(cx - 1);
            roll_column(cx);
        end
        if (cx + 1 < w) begin
            col_cnt = cx + 1;
        end else begin
            col_cnt = 0;
            row_cnt = (cy + 1 < h) ? cy + 1 : 0;
        end
    endtask

    function automatic t_pixel random_pixel(bit smooth, t_pixel base);
        t_pixel px;
        for (int ch = 0; ch < 3; ch++) begin
            if (smooth) begin
                px[ch] = base[ch] + 8'($urandom_range(0, 12));
            end else begin
                case ($urandom_range(0, 7))
                    0:       px[ch] = 8'd0;
                    1:       px[ch] = 8'd255;
                    default: px[ch] = 8'($urandom_range(0, 255));
                endcase
            end
        end
        return px;
    endfunction

    function automatic t_pixel random_base();
        return rgb(8'($urandom_range(0, 243)), 8'($urandom_range(0, 243)),
                   8'($urandom_range(0, 243)));
    endfunction

    task automatic shuffle_idling();
        sender_gaps_on     = ($urandom_range(0, 3) != 0);
        receiver_stalls_on = ($urandom_range(0, 3) != 0);
    endtask

    // Offer one pixel after a random gap and hold it until the beat is taken
    task automatic send_pixel(t_pixel px);
        int unsigned gap;
        gap = sender_gaps_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_if.red_in   <= px[0];
        pix_if.green_in <= px[1];
        pix_if.blue_in  <= px[2];
        pix_if.valid    <= 1'b1;
        do @(negedge clk or posedge clk); while (!(clk && pix_if.ready));
        predict_pixel(px);
        @(negedge clk);
    endtask

    // Hold the source until every finished pixel is out and the pipeline is empty
    task automatic wait_for_idle();
        pix_if.valid <= 1'b0;
        while (pixels_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write a size register while idle; the frame restarts at the origin
    task automatic write_size(t_cfg_idx idx, t_cfg_data val);
        wait_for_idle();
        cfg_idx  <= idx;
        cfg_data <= val;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        col_cnt = 0;
        row_cnt = 0;
    endtask

    // Extremes of the values, wrapped negatives, frame wrap and a mid-frame resize
    task automatic test_edge_cases();
        t_pixel frame3 [9];
        frame3[0] = rgb(255, 0, 0);
        frame3[1] = rgb(0, 255, 0);
        frame3[2] = rgb(0, 0, 255);
        frame3[3] = rgb(0, 0, 0);
        frame3[4] = rgb(255, 255, 255);
        frame3[5] = rgb(0, 0, 0);
        frame3[6] = rgb(128, 64, 32);
        frame3[7] = rgb(255, 255, 255);
        frame3[8] = rgb(1, 2, 3);
        shuffle_idling();
        write_size(CFG_IMAGE_WIDTH, 12'd3);
        write_size(CFG_IMAGE_HEIGHT, 12'd3);
        for (int i = 0; i < 9; i++) begin
            send_pixel(frame3[i]);
            // hold the source mid-frame until all finished pixels are out
            if (i == 4) wait_for_idle();
        end
        // run on into the next frame without a write
        for (int i = 0; i < 3; i++) send_pixel(frame3[8 - i]);
        // resize part-way through a frame
        write_size(CFG_IMAGE_WIDTH, 12'd2);
        for (int i = 0; i < 6; i++) send_pixel(frame3[i + 3]);
    endtask

    // 1x1 frames: the sharpened value equals the input, so the whole curve is swept
    task automatic test_gamma_sweep();
        write_size(CFG_IMAGE_WIDTH, 12'd1);
        write_size(CFG_IMAGE_HEIGHT, 12'd1);
        for (int i = 0; i < 86; i++) begin
            if (i % 32 == 0) shuffle_idling();
            send_pixel(rgb(8'(i), 8'(i + 86), 8'(i + 172)));
        end
    endtask

    // Small random frames, partial frames, wraps and resizes
    task automatic test_random_frames();
        int unsigned sent, w, h, count;
        bit          smooth;
        t_pixel      base;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            if ($urandom_range(0, 1)) begin
                write_size(CFG_IMAGE_WIDTH, t_cfg_data'(w));
                write_size(CFG_IMAGE_HEIGHT, t_cfg_data'(h));
            end else begin
                write_size(CFG_IMAGE_HEIGHT, t_cfg_data'(h));
                write_size(CFG_IMAGE_WIDTH, t_cfg_data'(w));
            end
            shuffle_idling();
            smooth = $urandom_range(0, 1);
            base   = random_base();
            count  = $urandom_range(1, 2 * w * h + w);
            if (count > 100) count = 100;
            if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
            for (int i = 0; i < count; i++) begin
                if (i == count / 2 && $urandom_range(0, 3) == 0) wait_for_idle();
                if (i % 32 == 31) shuffle_idling();
                send_pixel(random_pixel(smooth, base));
            end
            sent += count;
        end
    endtask

    // Widest row: width above the maximum acts as the maximum, height zero as one
    task automatic test_widest_row();
        t_pixel base;
        base = random_base();
        write_size(CFG_IMAGE_WIDTH, 12'hFFF);
        write_size(CFG_IMAGE_HEIGHT, 12'h000);
        for (int i = 0; i < EDGE_ITEMS; i++) begin
            if (i % 8 == 0) shuffle_idling();
            send_pixel(random_pixel((i / 8) % 2 == 1, base));
        end
    endtask

    // Tallest column: width zero acts as one, height above the maximum as the maximum
    task automatic test_tallest_column();
        t_pixel base;
        base = random_base();
        write_size(CFG_IMAGE_WIDTH, 12'h000);
        write_size(CFG_IMAGE_HEIGHT, 12'hFFF);
        for (int i = 0; i < EDGE_ITEMS; i++) begin
            if (i % 8 == 0) shuffle_idling();
            send_pixel(random_pixel((i / 8) % 2 == 0, base));
        end
    endtask

    // Receiver: when stalls are on, drop ready for a random stall before each beat
    initial begin : result_sink
        int unsigned stall;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = receiver_stalls_on ? $urandom_range(0, 10) : 0;
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            @(negedge clk);
        end
    end

    // Compare each accepted beat with the oldest finished pixel due
    always @(posedge clk) begin : result_check
        t_finished_pixel want;
        t_finished_pixel got;
        if (rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.out_col, res_if.out_row, res_if.red_out, res_if.green_out,
                   res_if.blue_out, res_if.last_of_run, res_if.frame_done};
            if (pixels_due.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("cycle %0d: unexpected beat col=%0d row=%0d rgb=%0d/%0d/%0d",
                             cycle_count, got.col, got.row, got.red, got.green, got.blue);
            end else begin
                want = pixels_due.pop_front();
                if (got !== want) begin
                    bad_beats++;
                    if (bad_beats <= 10) begin
                        $display("cycle %0d: expected col=%0d row=%0d rgb=%0d/%0d/%0d last=%b done=%b",
                                 cycle_count, want.col, want.row, want.red, want.green,
                                 want.blue, want.last_of_run, want.frame_done);
                        $display("cycle %0d: actual   col=%0d row=%0d rgb=%0d/%0d/%0d last=%b done=%b",
                                 cycle_count, got.col, got.row, got.red, got.green,
                                 got.blue, got.last_of_run, got.frame_done);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_IMAGE_WIDTH;
        cfg_data        = '0;
        pix_if.valid    = 1'b0;
        pix_if.red_in   = '0;
        pix_if.green_in = '0;
        pix_if.blue_in  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_cases();
        test_gamma_sweep();
        test_random_frames();
        test_widest_row();
        test_tallest_column();

        wait_for_idle();
        if (bad_beats == 0 && pixels_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
